[rtl/mpe_pkg.sv]
package mpe_pkg;

  // field and datapath widths
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned Q_W        = 64;
  localparam int unsigned SCALE_W    = 60;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned ACC_W      = 128;
  localparam int unsigned DIFF_W     = 14;
  localparam int unsigned MAP_MAG_W  = 13;

  // frame geometry and iteration limit
  localparam int unsigned STEP_LIMIT_DEF = 255;
  localparam int unsigned FRAME_ROWS     = 1080;
  localparam logic [DIFF_W-1:0] HALF_ROWS = DIFF_W'(FRAME_ROWS / 2);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_OFFSET = 2'd2;

  // register values after reset
  localparam logic [SCALE_W-1:0] SCALE_RESET    = 60'd2305843009213694;
  localparam logic [Q_W-1:0]     REAL_OFF_RESET = 64'hF800_0000_0000_0000;
  localparam logic [Q_W-1:0]     IMAG_OFF_RESET = 64'h0;

  // color levels
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_RED   = 8'd150;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 8'd0;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_column;
    logic [PIX_W-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] step_count;
    logic               inside_set;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } pix_out_t;

  typedef struct packed {
    logic [SCALE_W-1:0] pixel_scale;
    logic [Q_W-1:0]     real_offset;
    logic [Q_W-1:0]     imag_offset;
  } cfg_regs_t;

  // which product a run of partial products belongs to
  typedef enum logic [2:0] {
    TAG_MAP_RE = 3'd0,
    TAG_MAP_IM = 3'd1,
    TAG_SQ_RE  = 3'd2,
    TAG_SQ_IM  = 3'd3,
    TAG_CROSS  = 3'd4
  } mac_tag_t;

  // one partial product issued to the multiplier
  typedef struct packed {
    logic       issue;
    logic       first;
    logic       last;
    logic [1:0] shift_words;
    mac_tag_t   tag;
  } mac_ctl_t;

  // product complete in the accumulator
  typedef struct packed {
    logic     done;
    mac_tag_t tag;
  } mac_stat_t;

endpackage

[rtl/mpe_mac.sv]
module mpe_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpe_pkg::mac_ctl_t             ctl,
  input  logic [mpe_pkg::HALF_W-1:0]    op_a,
  input  logic [mpe_pkg::HALF_W-1:0]    op_b,
  output logic [mpe_pkg::ACC_W-1:0]     acc,
  output mpe_pkg::mac_stat_t            stat
);

  logic [2*mpe_pkg::HALF_W-1:0] prod_r;
  mpe_pkg::mac_ctl_t            ctl1_r;
  logic [mpe_pkg::ACC_W-1:0]    acc_r;
  logic [mpe_pkg::ACC_W-1:0]    addend;
  logic [mpe_pkg::ACC_W-1:0]    acc_nxt;
  mpe_pkg::mac_stat_t           stat_r;

  // product stage
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl;
    end
  end

  // align the partial product to its word position
  always_comb begin
    case (ctl1_r.shift_words)
      2'd0:    addend = {64'b0, prod_r};
      2'd1:    addend = {32'b0, prod_r, 32'b0};
      default: addend = {prod_r, 64'b0};
    endcase
    acc_nxt = (ctl1_r.first ? '0 : acc_r) + addend;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl1_r.issue) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r.done <= ctl1_r.issue & ctl1_r.last;
      stat_r.tag  <= ctl1_r.tag;
    end
  end

  assign acc  = acc_r;
  assign stat = stat_r;

endmodule

[rtl/mpe_engine.sv]
module mpe_engine #(
  parameter int unsigned STEP_LIMIT = mpe_pkg::STEP_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mpe_pkg::pix_in_t    pix,
  input  mpe_pkg::cfg_regs_t  cfg,
  output logic                ready,
  output logic                res_valid,
  output mpe_pkg::pix_out_t   res,
  input  logic                res_take
);

  localparam int unsigned CNT_W = $clog2(STEP_LIMIT + 1);
  localparam logic [3:0] PHASE_MAP_LAST  = 4'd3;
  localparam logic [3:0] PHASE_STEP_LAST = 4'd11;
  localparam logic [mpe_pkg::Q_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;
  localparam logic [mpe_pkg::Q_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_MAP_MUL   = 7'b0000010,
    S_MAP_WAIT  = 7'b0000100,
    S_STEP_MAG  = 7'b0001000,
    S_STEP_MUL  = 7'b0010000,
    S_STEP_WAIT = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  // scaled pixel offset plus axis offset, saturated to Q4.60
  function automatic logic [mpe_pkg::Q_W-1:0] map_sat(
    input logic [72:0]               prod,
    input logic                      neg,
    input logic [mpe_pkg::Q_W-1:0]   off
  );
    logic signed [74:0] term;
    logic signed [74:0] sum;
    term = neg ? -$signed({2'b0, prod}) : $signed({2'b0, prod});
    sum  = term + $signed({{11{off[63]}}, off});
    if ((&sum[74:63]) || !(|sum[74:63])) begin
      return sum[63:0];
    end else if (sum[74]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  state_t                            state_r, state_nxt;
  logic [3:0]                        phase_r, phase_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [mpe_pkg::MAP_MAG_W-1:0]     map_mag_re_r, map_mag_im_r;
  logic                              map_neg_re_r, map_neg_im_r;
  logic [mpe_pkg::Q_W-1:0]           cr_r, ci_r, zr_r, zi_r;
  logic [mpe_pkg::Q_W-1:0]           mag_re_r, mag_im_r;
  logic [mpe_pkg::ACC_W-1:0]         pr_r, pi_r;

  logic signed [mpe_pkg::DIFF_W-1:0] d_col, d_row;
  mpe_pkg::mac_ctl_t                 mac_ctl;
  logic [mpe_pkg::HALF_W-1:0]        op_a, op_b;
  logic [mpe_pkg::ACC_W-1:0]         acc;
  mpe_pkg::mac_stat_t                mac_stat;
  logic [mpe_pkg::Q_W-1:0]           map_val;
  logic [mpe_pkg::ACC_W-1:0]         sq_sum;
  logic                              escaped;
  logic [mpe_pkg::Q_W-1:0]           cross_q, ri, zr_upd, zi_upd;
  logic                              cross_rem, cross_neg;
  logic                              cross_done, step_go;
  logic                              limit_hit;

  mpe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc),
    .stat  (mac_stat)
  );

  // pixel distance from the frame center
  assign d_col = $signed({3'b0, pix.pixel_column}) - $signed(mpe_pkg::HALF_ROWS);
  assign d_row = $signed({3'b0, pix.pixel_row}) - $signed(mpe_pkg::HALF_ROWS);

  // partial product schedule for the shared multiplier
  always_comb begin
    logic [mpe_pkg::Q_W-1:0] x;
    logic [mpe_pkg::Q_W-1:0] y;
    x       = (phase_r[3:2] == 2'd1) ? mag_im_r : mag_re_r;
    y       = (phase_r[3:2] == 2'd0) ? mag_re_r : mag_im_r;
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    case (state_r)
      S_MAP_MUL: begin
        mac_ctl.issue       = 1'b1;
        mac_ctl.first       = !phase_r[0];
        mac_ctl.last        = phase_r[0];
        mac_ctl.shift_words = {1'b0, phase_r[0]};
        mac_ctl.tag         = phase_r[1] ? mpe_pkg::TAG_MAP_IM : mpe_pkg::TAG_MAP_RE;
        op_a = {19'b0, phase_r[1] ? map_mag_im_r : map_mag_re_r};
        op_b = phase_r[0] ? {4'b0, cfg.pixel_scale[59:32]} : cfg.pixel_scale[31:0];
      end
      S_STEP_MUL: begin
        mac_ctl.issue       = 1'b1;
        mac_ctl.first       = (phase_r[1:0] == 2'd0);
        mac_ctl.last        = (phase_r[1:0] == 2'd3);
        mac_ctl.shift_words = {1'b0, phase_r[1]} + {1'b0, phase_r[0]};
        case (phase_r[3:2])
          2'd0:    mac_ctl.tag = mpe_pkg::TAG_SQ_RE;
          2'd1:    mac_ctl.tag = mpe_pkg::TAG_SQ_IM;
          default: mac_ctl.tag = mpe_pkg::TAG_CROSS;
        endcase
        op_a = phase_r[1] ? x[63:32] : x[31:0];
        op_b = phase_r[0] ? y[63:32] : y[31:0];
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // mapped coordinate from the finished scale product
  assign map_val = map_sat(acc[72:0],
                           (mac_stat.tag == mpe_pkg::TAG_MAP_IM) ? map_neg_im_r : map_neg_re_r,
                           (mac_stat.tag == mpe_pkg::TAG_MAP_IM) ? cfg.imag_offset
                                                                 : cfg.real_offset);

  // escape test and next z from the three products
  assign sq_sum    = pr_r + pi_r;
  assign escaped   = |sq_sum[127:122];
  assign zr_upd    = pr_r[123:60] - pi_r[123:60] + cr_r;
  assign cross_q   = acc[122:59];
  assign cross_rem = |acc[58:0];
  assign cross_neg = zr_r[63] ^ zi_r[63];
  assign ri        = cross_neg ? (~cross_q + {63'b0, ~cross_rem}) : cross_q;
  assign zi_upd    = ri + ci_r;

  assign cross_done = (state_r == S_STEP_WAIT) && mac_stat.done &&
                      (mac_stat.tag == mpe_pkg::TAG_CROSS);
  assign step_go    = cross_done && !escaped && (count_r != CNT_W'(STEP_LIMIT));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MAP_MUL;
          phase_nxt = '0;
          count_nxt = '0;
        end
      end
      S_MAP_MUL: begin
        phase_nxt = phase_r + 4'd1;
        if (phase_r == PHASE_MAP_LAST) begin
          state_nxt = S_MAP_WAIT;
          phase_nxt = '0;
        end
      end
      S_MAP_WAIT: begin
        if (mac_stat.done && (mac_stat.tag == mpe_pkg::TAG_MAP_IM)) begin
          state_nxt = S_STEP_MAG;
        end
      end
      S_STEP_MAG: begin
        state_nxt = S_STEP_MUL;
      end
      S_STEP_MUL: begin
        phase_nxt = phase_r + 4'd1;
        if (phase_r == PHASE_STEP_LAST) begin
          state_nxt = S_STEP_WAIT;
          phase_nxt = '0;
        end
      end
      S_STEP_WAIT: begin
        if (cross_done) begin
          if (escaped) begin
            // a point that starts outside counts one step
            if (count_r == '0) begin
              count_nxt = CNT_W'(1);
            end
            state_nxt = S_DONE;
          end else if (count_r == CNT_W'(STEP_LIMIT)) begin
            state_nxt = S_DONE;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            state_nxt = S_STEP_MAG;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      map_neg_re_r <= d_col[13];
      map_neg_im_r <= d_row[13];
      map_mag_re_r <= d_col[13] ? 13'(-d_col) : d_col[12:0];
      map_mag_im_r <= d_row[13] ? 13'(-d_row) : d_row[12:0];
    end
    if (state_r == S_STEP_MAG) begin
      mag_re_r <= zr_r[63] ? -zr_r : zr_r;
      mag_im_r <= zi_r[63] ? -zi_r : zi_r;
    end
    if (mac_stat.done) begin
      case (mac_stat.tag)
        mpe_pkg::TAG_MAP_RE: cr_r <= map_val;
        mpe_pkg::TAG_MAP_IM: begin
          ci_r <= map_val;
          zr_r <= cr_r;
          zi_r <= map_val;
        end
        mpe_pkg::TAG_SQ_RE: pr_r <= acc;
        mpe_pkg::TAG_SQ_IM: pi_r <= acc;
        default: begin
        end
      endcase
    end
    if (step_go) begin
      zr_r <= zr_upd;
      zi_r <= zi_upd;
    end
  end

  // result fields
  assign limit_hit       = (count_r >= CNT_W'(STEP_LIMIT));
  assign res.step_count  = 8'(count_r);
  assign res.inside_set  = limit_hit;
  assign res.red_level   = limit_hit ? mpe_pkg::LEVEL_FULL : mpe_pkg::LEVEL_RED;
  assign res.green_level = limit_hit ? mpe_pkg::LEVEL_FULL : mpe_pkg::LEVEL_ZERO;
  assign res.blue_level  = (limit_hit || (count_r > CNT_W'(1))) ? mpe_pkg::LEVEL_FULL
                                                                 : mpe_pkg::LEVEL_ZERO;

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

endmodule

[rtl/mandelbrot_pixel_escape.sv]
// throughput: one pixel at a time; each step issues 12 partial products on the single
// shared 32x32 multiplier, plus states for magnitude, drain and update
// reset: rst_n synchronous active low; clears the sequencer and output valid and
// restores the configuration registers to their reset values
module mandelbrot_pixel_escape #(
  parameter int unsigned STEP_LIMIT = mpe_pkg::STEP_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mpe_pkg::pix_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mpe_pkg::pix_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [mpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mpe_pkg::cfg_regs_t cfg_r;
  logic               eng_ready;
  logic               eng_res_valid;
  mpe_pkg::pix_out_t  eng_res;
  logic               res_take;
  logic               out_valid_r;
  mpe_pkg::pix_out_t  out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_scale <= mpe_pkg::SCALE_RESET;
      cfg_r.real_offset <= mpe_pkg::REAL_OFF_RESET;
      cfg_r.imag_offset <= mpe_pkg::IMAG_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpe_pkg::CFG_PIXEL_SCALE: cfg_r.pixel_scale <= cfg_data[mpe_pkg::SCALE_W-1:0];
        mpe_pkg::CFG_REAL_OFFSET: cfg_r.real_offset <= cfg_data;
        mpe_pkg::CFG_IMAG_OFFSET: cfg_r.imag_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mpe_engine #(
    .STEP_LIMIT (STEP_LIMIT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && !in_stall),
    .pix       (in_data),
    .cfg       (cfg_r),
    .ready     (eng_ready),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_take  (res_take)
  );

  assign in_stall = !eng_ready || !rst_n;

  // output register: engine hands over when it is empty or being drained
  assign res_take = eng_res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= eng_res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/mpe_checker.sv]
module mpe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mpe_pkg::pix_out_t out_data
);

  // one pixel in flight: a transfer in closes the input side
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a pixel is still in work");

  // a new result only appears after a busy cycle of the engine
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in work");

  // colors follow the inside flag
  a_color_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.inside_set ?
      (out_data.red_level == mpe_pkg::LEVEL_FULL &&
       out_data.green_level == mpe_pkg::LEVEL_FULL &&
       out_data.blue_level == mpe_pkg::LEVEL_FULL) :
      (out_data.red_level == mpe_pkg::LEVEL_RED &&
       out_data.green_level == mpe_pkg::LEVEL_ZERO)))
    else $error("color levels disagree with inside flag");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (.*);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpe_pkg::*;

  localparam int unsigned STEP_LIMIT   = STEP_LIMIT_DEF;
  localparam int unsigned RANDOM_TOTAL = 1530;
  localparam int unsigned DRAIN_CYCLES = 4000;
  localparam int unsigned CYCLE_LIMIT  = 20_000_000;

  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // signed Q4.60 limits and frame center, at product width
  localparam logic signed [ACC_W-1:0] HALF_FRAME = FRAME_ROWS / 2;
  localparam logic signed [ACC_W-1:0] Q_TOP      = {65'd0, {63{1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_BOTTOM   = -Q_TOP - 1;

  // plane near c = 0.25 + eps where escape takes about the full step limit
  localparam logic [SCALE_W-1:0] RIM_SCALE = 60'd576460752303;
  localparam logic [Q_W-1:0]     RIM_REAL  = 64'd288460960452633113;

  // zoom onto the boundary around -0.75 + 0.1i, step 1/1000
  localparam logic [Q_W-1:0] ZOOM_SCALE = 64'd1152921504606847;
  localparam logic [Q_W-1:0] ZOOM_REAL  = 64'hF400_0000_0000_0000;
  localparam logic [Q_W-1:0] ZOOM_IMAG  = 64'd115292150460684698;

  localparam pix_out_t FAR_COLOR = '{step_count: 8'd1, inside_set: 1'b0,
                                     red_level: LEVEL_RED, green_level: LEVEL_ZERO,
                                     blue_level: LEVEL_ZERO};
  localparam pix_out_t INSIDE_COLOR = '{step_count: 8'(STEP_LIMIT), inside_set: 1'b1,
                                        red_level: LEVEL_FULL, green_level: LEVEL_FULL,
                                        blue_level: LEVEL_FULL};

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICTED,
    ROW_TYPED
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    pix_in_t               pixel;
    pix_out_t              color;
  } plan_row_t;

  typedef struct {
    pix_in_t  pixel;
    pix_out_t color;
  } pixel_color_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copy used for prediction
  logic [SCALE_W-1:0] scale_q    = SCALE_RESET;
  logic [Q_W-1:0]     real_off_q = REAL_OFF_RESET;
  logic [Q_W-1:0]     imag_off_q = IMAG_OFF_RESET;

  pixel_color_t expected_colors[$];
  plan_row_t    plan[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  random_sent = 0;
  int unsigned  send_gap_pct = 37;
  int unsigned  recv_stall_pct = 76;

  mandelbrot_pixel_escape #(
    .STEP_LIMIT(STEP_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // pixel to plane coordinate, saturated to Q4.60
  function automatic logic [Q_W-1:0] plane_coord(input logic [PIX_W-1:0] pix,
                                                 input logic [SCALE_W-1:0] pitch,
                                                 input logic [Q_W-1:0] offset);
    logic signed [ACC_W-1:0] span;
    logic signed [ACC_W-1:0] point;
    span  = $signed({{(ACC_W-PIX_W){1'b0}}, pix}) - HALF_FRAME;
    point = span * $signed({{(ACC_W-SCALE_W){1'b0}}, pitch})
          + $signed({{(ACC_W-Q_W){offset[Q_W-1]}}, offset});
    if (point > Q_TOP)
      return Q_TOP[Q_W-1:0];
    if (point < Q_BOTTOM)
      return Q_BOTTOM[Q_W-1:0];
    return point[Q_W-1:0];
  endfunction

  // floor(a*b / 2^shift), wrapped to 64 bits
  function automatic logic [Q_W-1:0] fixed_product(input logic [Q_W-1:0] a,
                                                   input logic [Q_W-1:0] b,
                                                   input int unsigned shift);
    logic signed [ACC_W-1:0] wa;
    logic signed [ACC_W-1:0] wb;
    logic signed [ACC_W-1:0] prod;
    wa   = $signed({{(ACC_W-Q_W){a[Q_W-1]}}, a});
    wb   = $signed({{(ACC_W-Q_W){b[Q_W-1]}}, b});
    prod = (wa * wb) >>> shift;
    return prod[Q_W-1:0];
  endfunction

  // exact |z|^2 >= 4
  function automatic bit beyond_radius(input logic [Q_W-1:0] re, input logic [Q_W-1:0] im);
    logic [Q_W-1:0]   mag_re;
    logic [Q_W-1:0]   mag_im;
    logic [ACC_W-1:0] wr;
    logic [ACC_W-1:0] wi;
    mag_re = re[Q_W-1] ? -re : re;
    mag_im = im[Q_W-1] ? -im : im;
    wr = {{(ACC_W-Q_W){1'b0}}, mag_re};
    wi = {{(ACC_W-Q_W){1'b0}}, mag_im};
    return (wr * wr + wi * wi) >= ({{(ACC_W-1){1'b0}}, 1'b1} << 122);
  endfunction

  // iteration count for point c; escaped tells escape from the step limit
  function automatic int unsigned escape_steps(input logic [Q_W-1:0] c_re,
                                               input logic [Q_W-1:0] c_im,
                                               output bit escaped);
    logic [Q_W-1:0] zr;
    logic [Q_W-1:0] zi;
    logic [Q_W-1:0] rr;
    logic [Q_W-1:0] ii;
    logic [Q_W-1:0] ri;
    int unsigned    steps;
    zr = c_re;
    zi = c_im;
    steps = 0;
    escaped = 1'b1;
    // far point: first step escapes by construction
    if (beyond_radius(c_re, c_im))
      return 1;
    while (steps < STEP_LIMIT) begin
      rr = fixed_product(zr, zr, 60);
      ii = fixed_product(zi, zi, 60);
      ri = fixed_product(zr, zi, 59);
      zr = rr - ii + c_re;
      zi = ri + c_im;
      steps++;
      if (beyond_radius(zr, zi))
        return steps;
    end
    escaped = 1'b0;
    return steps;
  endfunction

  function automatic pix_out_t predict_color(input pix_in_t px);
    pix_out_t    color;
    int unsigned steps;
    bit          escaped;
    bit          bounded;
    steps = escape_steps(plane_coord(px.pixel_column, scale_q, real_off_q),
                         plane_coord(px.pixel_row, scale_q, imag_off_q), escaped);
    bounded = steps >= STEP_LIMIT;
    color.step_count  = 8'(steps);
    color.inside_set  = bounded;
    color.red_level   = bounded ? LEVEL_FULL : LEVEL_RED;
    color.green_level = bounded ? LEVEL_FULL : LEVEL_ZERO;
    color.blue_level  = (bounded || steps >= 2) ? LEVEL_FULL : LEVEL_ZERO;
    return color;
  endfunction

  function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PIXEL_SCALE: scale_q = data[SCALE_W-1:0];
      CFG_REAL_OFFSET: real_off_q = data;
      CFG_IMAG_OFFSET: imag_off_q = data;
      default: ;
    endcase
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = data;
    r.pixel = '0;
    r.color = '0;
    return r;
  endfunction

  function automatic plan_row_t pixel_row(input int unsigned col, input int unsigned row);
    plan_row_t r;
    r.kind  = ROW_PREDICTED;
    r.index = '0;
    r.data  = '0;
    r.pixel = '{pixel_column: PIX_W'(col), pixel_row: PIX_W'(row)};
    r.color = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input int unsigned col, input int unsigned row,
                                          input pix_out_t color);
    plan_row_t r;
    r = pixel_row(col, row);
    r.kind  = ROW_TYPED;
    r.color = color;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 100)
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // one transfer on the pixel channel, expectation queued on acceptance
  task automatic send_pixel(input pix_in_t px, input pix_out_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    expected_colors.push_back('{pixel: px, color: want});
  endtask

  task automatic wait_for_colors();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register_write(idx, data);
  endtask

  // reprogram the plane while idle, then random pixels over it
  task automatic run_plane_phase(input logic [CFG_DATA_W-1:0] scale_word,
                                 input logic [CFG_DATA_W-1:0] re_word,
                                 input logic [CFG_DATA_W-1:0] im_word,
                                 input int unsigned items);
    pix_in_t px;
    wait_for_colors();
    write_register(CFG_PIXEL_SCALE, scale_word);
    write_register(CFG_UNUSED, {$urandom, $urandom});
    write_register(CFG_REAL_OFFSET, re_word);
    write_register(CFG_IMAG_OFFSET, im_word);
    cfg_we <= 1'b0;
    repeat (items) begin
      // receiver stalls, then sender idles, then neither
      case (random_sent * 3 / RANDOM_TOTAL)
        0: begin
          send_gap_pct   = 37;
          recv_stall_pct = 76;
        end
        1: begin
          send_gap_pct   = 76;
          recv_stall_pct = 37;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      px.pixel_column = PIX_W'($urandom);
      px.pixel_row    = PIX_W'($urandom);
      send_pixel(px, predict_color(px));
      random_sent++;
    end
  endtask

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    pixel_color_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", out_data));
      end else begin
        want = expected_colors.pop_front();
        if (out_data.step_count !== want.color.step_count)
          report_mismatch($sformatf("pixel (%0d,%0d) step_count %0d, want %0d",
            want.pixel.pixel_column, want.pixel.pixel_row,
            out_data.step_count, want.color.step_count));
        if (out_data.inside_set !== want.color.inside_set)
          report_mismatch($sformatf("pixel (%0d,%0d) inside_set %0b, want %0b",
            want.pixel.pixel_column, want.pixel.pixel_row,
            out_data.inside_set, want.color.inside_set));
        if (out_data.red_level !== want.color.red_level)
          report_mismatch($sformatf("pixel (%0d,%0d) red_level %0d, want %0d",
            want.pixel.pixel_column, want.pixel.pixel_row,
            out_data.red_level, want.color.red_level));
        if (out_data.green_level !== want.color.green_level)
          report_mismatch($sformatf("pixel (%0d,%0d) green_level %0d, want %0d",
            want.pixel.pixel_column, want.pixel.pixel_row,
            out_data.green_level, want.color.green_level));
        if (out_data.blue_level !== want.color.blue_level)
          report_mismatch($sformatf("pixel (%0d,%0d) blue_level %0d, want %0d",
            want.pixel.pixel_column, want.pixel.pixel_row,
            out_data.blue_level, want.color.blue_level));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned steps;
    bit          escaped;
    bit          writing;
    longint      jitter;
    longint      spread_re;
    longint      spread_im;

    // first column on the rim plane that escapes within the step limit
    lo = 0;
    hi = FRAME_ROWS / 2;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      steps = escape_steps(plane_coord(PIX_W'(mid), RIM_SCALE, RIM_REAL),
                           plane_coord(PIX_W'(FRAME_ROWS / 2), RIM_SCALE, '0), escaped);
      if (escaped)
        hi = mid;
      else
        lo = mid;
    end

    // reset plane: center, far corners, alternating bits
    plan.push_back(typed_row(540, 540, INSIDE_COLOR));
    plan.push_back(typed_row(2047, 0, FAR_COLOR));
    plan.push_back(pixel_row(0, 0));
    plan.push_back(typed_row(2047, 2047, FAR_COLOR));
    plan.push_back(typed_row(0, 2047, FAR_COLOR));
    plan.push_back(pixel_row(1365, 682));
    plan.push_back(pixel_row(682, 1365));
    plan.push_back(pixel_row(540, 0));
    // largest scale, written with the unused top bits set; saturation edges
    plan.push_back(write_row(CFG_PIXEL_SCALE, '1));
    plan.push_back(write_row(CFG_REAL_OFFSET, '0));
    plan.push_back(write_row(CFG_IMAG_OFFSET, '0));
    plan.push_back(typed_row(0, 0, FAR_COLOR));
    plan.push_back(typed_row(2047, 2047, FAR_COLOR));
    plan.push_back(typed_row(540, 540, INSIDE_COLOR));
    plan.push_back(pixel_row(541, 540));
    plan.push_back(pixel_row(539, 540));
    plan.push_back(typed_row(548, 540, FAR_COLOR));
    plan.push_back(typed_row(549, 540, FAR_COLOR));
    plan.push_back(typed_row(532, 540, FAR_COLOR));
    plan.push_back(typed_row(531, 540, FAR_COLOR));
    // zero scale, offsets at their extremes
    plan.push_back(write_row(CFG_PIXEL_SCALE, '0));
    plan.push_back(write_row(CFG_REAL_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF));
    plan.push_back(write_row(CFG_IMAG_OFFSET, 64'h8000_0000_0000_0000));
    plan.push_back(typed_row(0, 0, FAR_COLOR));
    plan.push_back(typed_row(2047, 2047, FAR_COLOR));
    // c = -2 sits exactly on the radius, one lsb inside does not
    plan.push_back(write_row(CFG_REAL_OFFSET, 64'hE000_0000_0000_0000));
    plan.push_back(write_row(CFG_IMAG_OFFSET, '0));
    plan.push_back(typed_row(100, 100, FAR_COLOR));
    plan.push_back(write_row(CFG_REAL_OFFSET, 64'hE000_0000_0000_0001));
    plan.push_back(pixel_row(7, 9));
    // escape on the very last step, and its bounded neighbor
    plan.push_back(write_row(CFG_PIXEL_SCALE, {4'd0, RIM_SCALE}));
    plan.push_back(write_row(CFG_REAL_OFFSET, RIM_REAL));
    plan.push_back(write_row(CFG_UNUSED, '1));
    plan.push_back(pixel_row(hi, 540));
    plan.push_back(pixel_row(hi - 1, 540));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) begin
          wait_for_colors();
          writing = 1'b1;
        end
        write_register(plan[i].index, plan[i].data);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_pixel(plan[i].pixel,
                   plan[i].kind == ROW_TYPED ? plan[i].color : predict_color(plan[i].pixel));
      end
    end

    // random pixels over a series of planes
    run_plane_phase({4'($urandom), SCALE_RESET}, REAL_OFF_RESET, IMAG_OFF_RESET, 400);
    spread_re = $signed({$urandom, $urandom}) >>> 2;
    spread_im = $signed({$urandom, $urandom}) >>> 2;
    run_plane_phase(64'h0010_0000_0000_0000, spread_re, spread_im, 300);
    run_plane_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 200);
    run_plane_phase('0, {$urandom, $urandom}, {$urandom, $urandom}, 130);
    jitter = $signed({$urandom, $urandom}) >>> 14;
    run_plane_phase(ZOOM_SCALE, ZOOM_REAL + jitter, ZOOM_IMAG, 200);
    spread_re = $signed({$urandom, $urandom}) >>> 2;
    spread_im = $signed({$urandom, $urandom}) >>> 2;
    run_plane_phase({4'($urandom), SCALE_RESET}, spread_re, spread_im, 300);

    // drain and watch for stray results
    wait_for_colors();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
